[rtl/core/sdwu_pkg.sv]
// ----------------------------------------------------------------------------
// sdwu_pkg: shared types, constants and the STDP curve generator
// Holds the queue entry and control types, register indexes, reset values and
// the fixed-point function that builds the plasticity curve table.
// ----------------------------------------------------------------------------
package sdwu_pkg;

	localparam int QUEUE_DEPTH_DEF   = 16;
	localparam int CURVE_ENTRIES_DEF = 256;

	localparam int CURVE_W  = 17;
	localparam int TAU_W    = 34;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_WEIGHT = 2'd2;

	localparam logic signed [31:0] AMPLITUDE_RST   = 32'sd65536;
	localparam logic [31:0]        DELAY_RST       = 32'd0;
	localparam logic [31:0]        INIT_WEIGHT_RST = 32'd0;

	localparam logic [32:0] NONE_PENDING = 33'h1_0000_0000;
	localparam logic [31:0] WEIGHT_MAX   = 32'hFFFF_FFFF;

	localparam logic signed [49:0] SCALE_ROUND = 50'sd16384;
	localparam logic signed [34:0] DELTA_MAX   = 35'sd2147483647;
	localparam logic signed [34:0] DELTA_MIN   = -35'sd2147483648;

	localparam longint unsigned Q30_ONE  = 64'd1 << 30;
	localparam longint unsigned Q30_HALF = 64'd1 << 29;
	localparam longint unsigned POS_M    = 64'd59233784;
	localparam longint unsigned POS_R    = 64'd1050535106;
	localparam longint unsigned NEG_M    = 64'd69557092;
	localparam longint unsigned NEG_R    = 64'd1046696726;

	typedef struct packed {
		logic [31:0]        due_time;
		logic signed [31:0] delta;
	} q_entry_t;

	typedef struct packed {
		logic     push;
		logic     pop;
		q_entry_t wr_entry;
	} q_ctrl_t;

	function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
		return (a * b + Q30_HALF) >> 30;
	endfunction

	// Curve value in signed Q1.15 for a spike time difference of tau ticks.
	function automatic logic signed [CURVE_W-1:0] curve_value(int tau);
		longint unsigned pw;
		longint unsigned h;
		longint unsigned m;
		longint unsigned r;
		longint unsigned v;
		int n;
		pw = Q30_ONE;
		n = (tau < 0) ? -tau : tau;
		m = (tau < 0) ? NEG_M : POS_M;
		r = (tau < 0) ? NEG_R : POS_R;
		if (n == 0) begin
			return '0;
		end
		for (int i = 0; i < n; i++) begin
			pw = q30_mul(pw, r);
		end
		h = q30_mul(m, pw) * longint'(n);
		if (h >= Q30_ONE) begin
			h = Q30_ONE - 1;
		end
		for (int k = 0; k < 4; k++) begin
			h = q30_mul(h, h);
		end
		v = (h + (64'd1 << 14)) >> 15;
		if (tau < 0) begin
			return -$signed(CURVE_W'(v));
		end
		return $signed(CURVE_W'(v));
	endfunction

endpackage

[rtl/core/sdwu_curve_rom.sv]
// ----------------------------------------------------------------------------
// sdwu_curve_rom: STDP curve table
// Constant table of the plasticity curve, indexed by the offset spike time
// difference. Offsets outside the table read zero.
// ----------------------------------------------------------------------------
module sdwu_curve_rom #(
	parameter int ENTRIES = sdwu_pkg::CURVE_ENTRIES_DEF
) (
	input  logic signed [sdwu_pkg::TAU_W-1:0]   tau_idx,
	output logic signed [sdwu_pkg::CURVE_W-1:0] value
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic signed [sdwu_pkg::CURVE_W-1:0] rom_w [ENTRIES];
	logic                                in_range_w;
	logic [AW-1:0]                       addr_w;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_rom
		localparam logic signed [sdwu_pkg::CURVE_W-1:0] V =
			sdwu_pkg::curve_value(g - ENTRIES / 2);
		assign rom_w[g] = V;
	end

	assign in_range_w = !tau_idx[sdwu_pkg::TAU_W-1] &&
		(tau_idx[sdwu_pkg::TAU_W-2:0] < (sdwu_pkg::TAU_W-1)'(ENTRIES));
	assign addr_w = tau_idx[AW-1:0];
	assign value  = in_range_w ? rom_w[addr_w] : '0;

endmodule

[rtl/core/sdwu_delay_queue.sv]
// ----------------------------------------------------------------------------
// sdwu_delay_queue: queue of scheduled weight changes
// Circular buffer in a memory with a registered head entry. A write into the
// slot that becomes the head is forwarded straight into the head register.
// ----------------------------------------------------------------------------
module sdwu_delay_queue #(
	parameter int DEPTH = sdwu_pkg::QUEUE_DEPTH_DEF,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sdwu_pkg::q_ctrl_t  ctrl,
	output sdwu_pkg::q_entry_t head,
	output logic [CNT_W-1:0]   count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	sdwu_pkg::q_entry_t entries_q [DEPTH];
	sdwu_pkg::q_entry_t head_entry_q;
	logic [PTR_W-1:0]   head_ptr_q;
	logic [CNT_W-1:0]   count_q;

	logic [PTR_W:0]   slot_sum_w;
	logic [PTR_W:0]   slot_w;
	logic [PTR_W-1:0] wr_ptr_w;
	logic [PTR_W-1:0] head_inc_w;
	logic [PTR_W-1:0] rd_next_w;

	assign slot_sum_w = {1'b0, head_ptr_q} + (PTR_W+1)'(count_q);
	assign slot_w     = (slot_sum_w >= (PTR_W+1)'(DEPTH)) ?
		slot_sum_w - (PTR_W+1)'(DEPTH) : slot_sum_w;
	assign wr_ptr_w   = slot_w[PTR_W-1:0];
	assign head_inc_w = (head_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : head_ptr_q + 1'b1;
	assign rd_next_w  = ctrl.pop ? head_inc_w : head_ptr_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			entries_q[wr_ptr_w] <= ctrl.wr_entry;
		end
		if (ctrl.push && (wr_ptr_w == rd_next_w)) begin
			head_entry_q <= ctrl.wr_entry;
		end else begin
			head_entry_q <= entries_q[rd_next_w];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_ptr_q <= '0;
			count_q    <= '0;
		end else begin
			head_ptr_q <= rd_next_w;
			count_q    <= count_q - CNT_W'(ctrl.pop) + CNT_W'(ctrl.push);
		end
	end

	assign head  = head_entry_q;
	assign count = count_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count exceeds depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> (count_q != '0))
		else $error("queue popped while empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |-> ((count_q != CNT_W'(DEPTH)) || ctrl.pop))
		else $error("queue pushed while full");
`endif

endmodule

[rtl/core/stdp_delayed_weight_update.sv]
// ----------------------------------------------------------------------------
// stdp_delayed_weight_update: delayed STDP weight update for one synapse
// Applies due weight changes and schedules new ones from the STDP curve.
//
//   channel  handshake                 payload
//   input    in_valid / in_stall       now_time, spike_event,
//                                      source_spike_time, target_spike_time
//   output   out_valid / out_stall     weight, weight_changed, queue_overflow
//   config   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One beat is taken every cycle while in_stall is low; each beat passes the
// stage one, stage two and result registers before it is offered. Stage one looks up the curve and
// scales it with one multiply, stage two applies and schedules changes against
// the synapse state.
// Reset clears the pipeline and the queue, and loads the register reset values.
// Output stall holds the pipeline back stage by stage; empty stages still fill.
// ----------------------------------------------------------------------------
module stdp_delayed_weight_update #(
	parameter int QUEUE_DEPTH   = sdwu_pkg::QUEUE_DEPTH_DEF,
	parameter int CURVE_ENTRIES = sdwu_pkg::CURVE_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [31:0]                    now_time,
	input  logic                           spike_event,
	input  logic [31:0]                    source_spike_time,
	input  logic [31:0]                    target_spike_time,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [31:0]                    weight,
	output logic                           weight_changed,
	output logic                           queue_overflow,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sdwu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Configuration
	logic signed [31:0] amp_q;
	logic [31:0]        delay_q;

	// Stage one: input register
	logic        valid_s1;
	logic [31:0] now_s1;
	logic        ev_s1;
	logic [31:0] src_s1;
	logic [31:0] tgt_s1;

	// Stage two: scaled change
	logic               valid_s2;
	logic [31:0]        now_s2;
	logic               sched_s2;
	logic [31:0]        due_s2;
	logic signed [31:0] delta_s2;

	// Result register
	logic        out_valid_q;
	logic [31:0] weight_q;
	logic        changed_q;
	logic        ovf_q;

	// Synapse state
	logic [31:0]        cond_q;
	logic [32:0]        pend_time_q;
	logic signed [31:0] pend_delta_q;

	logic out_free_w, s2_go_w, s2_free_w, s1_go_w, s1_free_w, in_accept_w;

	logic signed [sdwu_pkg::TAU_W-1:0]   tau_idx_w;
	logic signed [sdwu_pkg::CURVE_W-1:0] curve_w;
	logic signed [49:0]                  prod_w;
	logic signed [49:0]                  rnd_w;
	logic signed [34:0]                  scaled_w;
	logic signed [31:0]                  delta_w;
	logic [32:0]                         due_sum_w;
	logic [31:0]                         due_w;
	logic                                sched_w;

	logic                 apply_w;
	logic signed [33:0]   sum_w;
	logic [31:0]          cond_applied_w;
	logic                 pnone_after_w;
	logic [CNT_W-1:0]     count_w;
	logic [CNT_W-1:0]     count_after_w;
	logic                 sched_go_w;
	logic                 set_pending_w;
	logic                 ovf_w;
	logic [31:0]          cond_next_w;
	logic [32:0]          pend_time_next_w;
	logic signed [31:0]   pend_delta_next_w;
	sdwu_pkg::q_ctrl_t    q_ctrl_w;
	sdwu_pkg::q_entry_t   q_head_w;

	// Handshake
	assign out_free_w  = !out_valid_q || !out_stall;
	assign s2_go_w     = valid_s2 && out_free_w;
	assign s2_free_w   = !valid_s2 || out_free_w;
	assign s1_go_w     = valid_s1 && s2_free_w;
	assign s1_free_w   = !valid_s1 || s2_free_w;
	assign in_accept_w = in_valid && s1_free_w;
	assign in_stall    = !s1_free_w;
	assign cfg_ready   = 1'b1;

	// Stage one logic
	assign tau_idx_w = $signed({2'b00, tgt_s1}) - $signed({2'b00, src_s1}) +
		$signed(sdwu_pkg::TAU_W'(CURVE_ENTRIES / 2));

	sdwu_curve_rom #(
		.ENTRIES(CURVE_ENTRIES)
	) u_curve_rom (
		.tau_idx(tau_idx_w),
		.value  (curve_w)
	);

	assign prod_w   = 50'(amp_q) * 50'(curve_w);
	assign rnd_w    = prod_w + sdwu_pkg::SCALE_ROUND;
	assign scaled_w = $signed(rnd_w[49:15]);

	always_comb begin
		if (scaled_w > sdwu_pkg::DELTA_MAX) begin
			delta_w = 32'sh7FFF_FFFF;
		end else if (scaled_w < sdwu_pkg::DELTA_MIN) begin
			delta_w = 32'sh8000_0000;
		end else begin
			delta_w = scaled_w[31:0];
		end
	end

	assign due_sum_w = {1'b0, now_s1} + {1'b0, delay_q};
	assign due_w     = due_sum_w[32] ? sdwu_pkg::WEIGHT_MAX : due_sum_w[31:0];
	assign sched_w   = ev_s1 && (src_s1 != '0) && (tgt_s1 != '0) && (curve_w != '0);

	// Stage two logic
	assign apply_w = s2_go_w && ({1'b0, now_s2} > pend_time_q);
	assign sum_w   = $signed({2'b00, cond_q}) + $signed({{2{pend_delta_q[31]}}, pend_delta_q});

	always_comb begin
		if (sum_w[33]) begin
			cond_applied_w = '0;
		end else if (sum_w[32]) begin
			cond_applied_w = sdwu_pkg::WEIGHT_MAX;
		end else begin
			cond_applied_w = sum_w[31:0];
		end
	end

	always_comb begin
		q_ctrl_w.pop          = apply_w && (count_w != '0);
		q_ctrl_w.wr_entry     = '{due_time: due_s2, delta: delta_s2};
		count_after_w         = count_w - CNT_W'(q_ctrl_w.pop);
		pnone_after_w         = apply_w ? (count_w == '0) : pend_time_q[32];
		sched_go_w            = s2_go_w && sched_s2;
		set_pending_w         = sched_go_w && pnone_after_w;
		q_ctrl_w.push         = sched_go_w && !pnone_after_w &&
			(count_after_w != CNT_W'(QUEUE_DEPTH));
		ovf_w                 = sched_go_w && !pnone_after_w &&
			(count_after_w == CNT_W'(QUEUE_DEPTH));
		cond_next_w           = apply_w ? cond_applied_w : cond_q;
		pend_time_next_w      = pend_time_q;
		pend_delta_next_w     = pend_delta_q;
		if (apply_w) begin
			if (q_ctrl_w.pop) begin
				pend_time_next_w  = {1'b0, q_head_w.due_time};
				pend_delta_next_w = q_head_w.delta;
			end else begin
				pend_time_next_w  = sdwu_pkg::NONE_PENDING;
			end
		end
		if (set_pending_w) begin
			pend_time_next_w  = {1'b0, due_s2};
			pend_delta_next_w = delta_s2;
		end
	end

	sdwu_delay_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_delay_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (q_ctrl_w),
		.head  (q_head_w),
		.count (count_w)
	);

	// Control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q         <= sdwu_pkg::AMPLITUDE_RST;
			delay_q       <= sdwu_pkg::DELAY_RST;
			cond_q        <= sdwu_pkg::INIT_WEIGHT_RST;
			pend_time_q   <= sdwu_pkg::NONE_PENDING;
			pend_delta_q  <= '0;
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (s1_free_w) begin
				valid_s1 <= in_valid;
			end
			if (s2_free_w) begin
				valid_s2 <= valid_s1;
			end
			if (out_free_w) begin
				out_valid_q <= valid_s2;
			end
			if (s2_go_w) begin
				cond_q       <= cond_next_w;
				pend_time_q  <= pend_time_next_w;
				pend_delta_q <= pend_delta_next_w;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					sdwu_pkg::CFG_AMPLITUDE: begin
						amp_q <= $signed(cfg_data);
					end
					sdwu_pkg::CFG_DELAY: begin
						delay_q <= cfg_data;
					end
					sdwu_pkg::CFG_INIT_WEIGHT: begin
						cond_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_accept_w) begin
			now_s1 <= now_time;
			ev_s1  <= spike_event;
			src_s1 <= source_spike_time;
			tgt_s1 <= target_spike_time;
		end
		if (s1_go_w) begin
			now_s2   <= now_s1;
			sched_s2 <= sched_w;
			due_s2   <= due_w;
			delta_s2 <= delta_w;
		end
		if (s2_go_w) begin
			weight_q  <= cond_next_w;
			changed_q <= apply_w;
			ovf_q     <= ovf_w;
		end
	end

	assign out_valid      = out_valid_q;
	assign weight         = weight_q;
	assign weight_changed = changed_q;
	assign queue_overflow = ovf_q;

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_valid_q))
		else $error("input stalled with a free pipeline stage");

	a_queue_implies_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(count_w != '0) |-> !pend_time_q[32])
		else $error("queued changes with nothing pending");

	a_ovf_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_w |-> (count_w == CNT_W'(QUEUE_DEPTH)))
		else $error("change dropped while queue had room");
`endif

endmodule
